// ===== hw/rtl/cbsm_pkg.sv =====
package cbsm_pkg;

  localparam int IndexWidth = 19;

  localparam logic [1:0] TgtNone   = 2'd0;
  localparam logic [1:0] TgtChrRom = 2'd1;
  localparam logic [1:0] TgtPrgRam = 2'd2;
  localparam logic [1:0] TgtPrgRom = 2'd3;

  localparam logic [1:0] GrpBank   = 2'd0;
  localparam logic [1:0] GrpMirror = 2'd1;
  localparam logic [1:0] GrpIrqCfg = 2'd2;
  localparam logic [1:0] GrpIrqEn  = 2'd3;

  localparam logic [1:0] CfgChrRomSize = 2'd0;
  localparam logic [1:0] CfgPrgRomSize = 2'd1;
  localparam logic [1:0] CfgPrgRamSize = 2'd2;

  localparam logic [4:0] ChrRomSizeReset = 5'd17;
  localparam logic [4:0] PrgRomSizeReset = 5'd18;
  localparam logic [3:0] PrgRamSizeReset = 4'd13;

  typedef struct packed {
    logic        mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            target;
    logic [IndexWidth-1:0] mem_index;
    logic [7:0]            open_bus_value;
    logic [1:0]            mirror_select;
    logic                  irq_enable_out;
    logic                  irq_reload_out;
    logic [7:0]            irq_latch_out;
    logic [7:0]            ram_protect_out;
  } out_item_t;

  typedef struct packed {
    logic [7:0]      bank_select;
    logic [5:0][7:0] chr_bank;
    logic [1:0][5:0] prg_bank;
    logic            mirror;
    logic [7:0]      ram_protect;
    logic [7:0]      irq_latch;
    logic            irq_reload;
    logic            irq_enable;
    logic [7:0]      last_write;
  } mapper_state_t;

  typedef struct packed {
    logic [4:0] chr_rom_size_log2;
    logic [4:0] prg_rom_size_log2;
    logic [3:0] prg_ram_size_log2;
  } size_cfg_t;

  // Low lg bits set; sizes past the index width give all ones.
  function automatic logic [IndexWidth-1:0] size_mask(input logic [4:0] lg);
    logic [IndexWidth-1:0] m;
    for (int i = 0; i < IndexWidth; i++) begin
      m[i] = (5'(i) < lg);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/cbsm_regs.sv =====
module cbsm_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  cbsm_pkg::in_item_t     item,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [4:0]             cfg_data,
  output cbsm_pkg::mapper_state_t state_next,
  output cbsm_pkg::size_cfg_t    cfg
);

  cbsm_pkg::mapper_state_t state;
  logic                    odd;
  logic [1:0]              grp;

  assign odd = item.address[0];
  assign grp = item.address[14:13];

  always_comb begin
    state_next = state;
    if (item.mode) begin
      state_next.last_write = item.write_data;
      if (item.address[15]) begin
        unique case (grp)
          cbsm_pkg::GrpBank: begin
            if (!odd) begin
              state_next.bank_select = item.write_data;
            end else begin
              unique case (state.bank_select[2:0])
                3'd0: state_next.chr_bank[0] = item.write_data & 8'hFE;
                3'd1: state_next.chr_bank[1] = item.write_data & 8'hFE;
                3'd2: state_next.chr_bank[2] = item.write_data;
                3'd3: state_next.chr_bank[3] = item.write_data;
                3'd4: state_next.chr_bank[4] = item.write_data;
                3'd5: state_next.chr_bank[5] = item.write_data;
                3'd6: state_next.prg_bank[0] = item.write_data[5:0];
                default: state_next.prg_bank[1] = item.write_data[5:0];
              endcase
            end
          end
          cbsm_pkg::GrpMirror: begin
            if (!odd) begin
              state_next.mirror = item.write_data[0];
            end else begin
              state_next.ram_protect = item.write_data;
            end
          end
          cbsm_pkg::GrpIrqCfg: begin
            if (!odd) begin
              state_next.irq_latch = item.write_data;
            end else begin
              state_next.irq_reload = 1'b1;
            end
          end
          default: begin
            state_next.irq_enable = odd;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chr_rom_size_log2 <= cbsm_pkg::ChrRomSizeReset;
      cfg.prg_rom_size_log2 <= cbsm_pkg::PrgRomSizeReset;
      cfg.prg_ram_size_log2 <= cbsm_pkg::PrgRamSizeReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbsm_pkg::CfgChrRomSize: cfg.chr_rom_size_log2 <= cfg_data;
        cbsm_pkg::CfgPrgRomSize: cfg.prg_rom_size_log2 <= cfg_data;
        cbsm_pkg::CfgPrgRamSize: cfg.prg_ram_size_log2 <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/cbsm_xlate.sv =====
module cbsm_xlate (
  input  cbsm_pkg::in_item_t      item,
  input  cbsm_pkg::mapper_state_t state_next,
  input  cbsm_pkg::size_cfg_t     cfg,
  output cbsm_pkg::out_item_t     result
);

  localparam int IW = cbsm_pkg::IndexWidth;

  logic [15:0]   a;
  logic [2:0]    slot;
  logic [7:0]    chr_bank;
  logic [10:0]   chr_off;
  logic [IW-1:0] chr_idx;
  logic [1:0]    win;
  logic [IW-1:0] prg_base;
  logic [IW-1:0] prg_idx;
  logic [IW-1:0] ram_idx;
  logic          in_ram;

  assign a      = item.address;
  assign in_ram = (a[15:13] == 3'b011);

  // CHR: two 2 KB windows and four 1 KB windows, halves swapped in CHR mode 1
  always_comb begin
    slot = a[12:10] ^ {state_next.bank_select[7], 2'b00};
    if (!slot[2]) begin
      chr_bank = state_next.chr_bank[{2'b00, slot[1]}];
      chr_off  = a[10:0];
    end else begin
      chr_bank = state_next.chr_bank[3'(slot - 3'd2)];
      chr_off  = {1'b0, a[9:0]};
    end
    chr_idx = ({1'b0, chr_bank, 10'd0} | {8'd0, chr_off})
              & cbsm_pkg::size_mask(cfg.chr_rom_size_log2);
  end

  // PRG: swap the first and third 8 KB windows in PRG mode 1
  always_comb begin
    win = a[14:13];
    if (state_next.bank_select[6] && !win[0]) begin
      win = {~win[1], 1'b0};
    end
    case (win)
      2'd0:    prg_base = {state_next.prg_bank[0], 13'd0};
      2'd1:    prg_base = {state_next.prg_bank[1], 13'd0};
      2'd2:    prg_base = {{(IW-14){1'b1}}, 14'd0};
      default: prg_base = {{(IW-13){1'b1}}, 13'd0};
    endcase
    prg_idx = (prg_base | {{(IW-13){1'b0}}, a[12:0]})
              & cbsm_pkg::size_mask(cfg.prg_rom_size_log2);
  end

  assign ram_idx = {{(IW-13){1'b0}}, a[12:0]}
                   & cbsm_pkg::size_mask({1'b0, cfg.prg_ram_size_log2});

  always_comb begin
    result.target    = cbsm_pkg::TgtNone;
    result.mem_index = '0;
    if (in_ram) begin
      result.target    = cbsm_pkg::TgtPrgRam;
      result.mem_index = ram_idx;
    end else if (!item.mode) begin
      if (a[15]) begin
        result.target    = cbsm_pkg::TgtPrgRom;
        result.mem_index = prg_idx;
      end else if (a[15:13] == 3'b000) begin
        result.target    = cbsm_pkg::TgtChrRom;
        result.mem_index = chr_idx;
      end
    end
    result.open_bus_value  = state_next.last_write;
    result.mirror_select   = {1'b1, state_next.mirror};
    result.irq_enable_out  = state_next.irq_enable;
    result.irq_reload_out  = state_next.irq_reload;
    result.irq_latch_out   = state_next.irq_latch;
    result.ram_protect_out = state_next.ram_protect;
  end

endmodule

// ===== hw/rtl/cartridge_bank_switch_mapper_unit.sv =====
// Bank-switching cartridge mapper (MMC3 style): each bus access gives one
// result with the target memory, byte index and register status after it.
// An access is registered on entry and its result is then registered in the
// output register; one access is taken every cycle while out_ready is high,
// and mapper register writes take effect for the very next access. The user
// must write the size registers through the cfg port only while idle; not enforced.
module cartridge_bank_switch_mapper_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cbsm_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cbsm_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [4:0]           cfg_data
);

  logic                    held_valid;
  cbsm_pkg::in_item_t      held;
  logic                    advance;
  logic                    fire;
  cbsm_pkg::mapper_state_t state_next;
  cbsm_pkg::size_cfg_t     cfg;
  cbsm_pkg::out_item_t     result;

  assign advance   = !out_valid || out_ready;
  assign fire      = held_valid && advance;
  assign in_ready  = !held_valid || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_item;
    end
  end

  cbsm_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .item       (held),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .state_next (state_next),
    .cfg        (cfg)
  );

  cbsm_xlate u_xlate (
    .item       (held),
    .state_next (state_next),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= result;
    end
  end

  a_none_zero_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.target == cbsm_pkg::TgtNone |-> out_item.mem_index == '0)
    else $error("open-bus result carries a nonzero index");

  a_mirror_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.mirror_select[1])
    else $error("mirror select outside its codes");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> held_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !held_valid)
    else $error("pipeline not empty after reset");

endmodule

// ===== sim/cartridge_bank_switch_mapper_unit_test.sv =====
module cartridge_bank_switch_mapper_unit_test;

  localparam logic       AccRead      = 1'b0;
  localparam logic       AccWrite     = 1'b1;
  localparam logic       Typed        = 1'b1;
  localparam logic       Predicted    = 1'b0;
  localparam logic [1:0] CfgUnused    = 2'd3;
  localparam int         PrgBankBase  = 6;
  localparam int         WideChrBanks = 2;
  localparam int         NumPhases    = 8;
  localparam int         PhaseItems   = 200;
  localparam int         SettleCycles = 8;
  localparam int         CycleLimit   = 400000;
  localparam int         ReportLimit  = 10;
  localparam int         IndexWidth   = cbsm_pkg::IndexWidth;

  typedef struct packed {
    cbsm_pkg::in_item_t    acc;
    logic                  typed;
    logic [1:0]            tgt;
    logic [IndexWidth-1:0] idx;
  } access_row_t;

  typedef struct packed {
    logic [4:0] chr;
    logic [4:0] prg;
    logic [4:0] ram;
  } size_plan_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  cbsm_pkg::in_item_t   in_item = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  cbsm_pkg::out_item_t  out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [4:0]           cfg_data = '0;

  int unsigned          idle_pct = 18;
  int unsigned          stall_pct = 18;
  int                   errors = 0;
  int                   cycle_count = 0;
  cbsm_pkg::out_item_t  pending_results[$];

  // Mapper register file as the predictor sees it
  logic [7:0]  bank_sel = '0;
  logic [7:0]  chr_bank [6] = '{default: '0};
  logic [5:0]  prg_bank [2] = '{default: '0};
  logic        mirror = 1'b0;
  logic [7:0]  protect = '0;
  logic [7:0]  latch = '0;
  logic        reload = 1'b0;
  logic        irq_en = 1'b0;
  logic [7:0]  last_wr = '0;
  logic [4:0]  chr_lg = cbsm_pkg::ChrRomSizeReset;
  logic [4:0]  prg_lg = cbsm_pkg::PrgRomSizeReset;
  logic [3:0]  ram_lg = cbsm_pkg::PrgRamSizeReset;

  access_row_t directed_rows [27] = '{
    '{'{AccRead,  16'h0000, 8'h00}, Typed, cbsm_pkg::TgtChrRom, 19'h00000},
    '{'{AccRead,  16'h1FFF, 8'h00}, Typed, cbsm_pkg::TgtChrRom, 19'h003FF},
    '{'{AccRead,  16'h2000, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccRead,  16'h5FFF, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccRead,  16'h6000, 8'h00}, Typed, cbsm_pkg::TgtPrgRam, 19'h00000},
    '{'{AccRead,  16'h7FFF, 8'h00}, Typed, cbsm_pkg::TgtPrgRam, 19'h01FFF},
    '{'{AccRead,  16'h8000, 8'h00}, Typed, cbsm_pkg::TgtPrgRom, 19'h00000},
    '{'{AccRead,  16'hC000, 8'h00}, Typed, cbsm_pkg::TgtPrgRom, 19'h3C000},
    '{'{AccRead,  16'hFFFF, 8'h00}, Typed, cbsm_pkg::TgtPrgRom, 19'h3FFFF},
    '{'{AccWrite, 16'h8000, 8'hC7}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h8001, 8'hFF}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h8000, 8'h06}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h8001, 8'hFF}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h8000, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h8001, 8'hFF}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h9FFE, 8'h05}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h9FFF, 8'hFF}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hA000, 8'h01}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hBFFF, 8'hA5}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hC000, 8'hFF}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hDFFF, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hE000, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'hFFFF, 8'h00}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccWrite, 16'h7FFF, 8'h3C}, Typed, cbsm_pkg::TgtPrgRam, 19'h01FFF},
    '{'{AccWrite, 16'h4000, 8'h81}, Typed, cbsm_pkg::TgtNone,   19'h00000},
    '{'{AccRead,  16'h0000, 8'h00}, Predicted, cbsm_pkg::TgtNone, 19'h00000},
    '{'{AccRead,  16'h8000, 8'h00}, Predicted, cbsm_pkg::TgtNone, 19'h00000}
  };

  // Extremes, oversized and all-zero sizes; the oversized RAM entry also tests truncation
  size_plan_t size_plan [NumPhases] = '{
    '{5'd10, 5'd14, 5'd0},
    '{5'd18, 5'd19, 5'd13},
    '{5'd31, 5'd31, 5'd31},
    '{5'd17, 5'd18, 5'd13},
    '{5'd0,  5'd0,  5'd0},
    '{5'd19, 5'd16, 5'd7},
    '{5'd20, 5'd20, 5'd12},
    '{5'd12, 5'd15, 5'd10}
  };

  cartridge_bank_switch_mapper_unit uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic [31:0] span_mask(input logic [4:0] lg);
    int n;
    n = (int'(lg) > IndexWidth) ? IndexWidth : int'(lg);
    return (32'd1 << n) - 32'd1;
  endfunction

  function automatic logic [31:0] chr_lookup(input logic [15:0] a);
    logic [2:0]  slot;
    logic [31:0] off;
    int          r;
    slot = a[12:10];
    if (bank_sel[7]) begin
      slot = slot ^ 3'd4;
    end
    if (slot < 3'd4) begin
      r = int'(slot) >> 1;
      off = 32'(a[10:0]);
    end else begin
      r = int'(slot) - 2;
      off = 32'(a[9:0]);
    end
    return ((32'(chr_bank[r]) << 10) | off) & span_mask(chr_lg);
  endfunction

  function automatic logic [31:0] prg_lookup(input logic [15:0] a);
    logic [1:0]  win;
    logic [31:0] base;
    win = a[14:13];
    // PRG mode 1 swaps the first window with the fixed second-to-last bank
    if (bank_sel[6] && !win[0]) begin
      win = win ^ 2'd2;
    end
    case (win)
      2'd0:    base = 32'(prg_bank[0]) << 13;
      2'd1:    base = 32'(prg_bank[1]) << 13;
      2'd2:    base = 32'hFFFF_C000;
      default: base = 32'hFFFF_E000;
    endcase
    return (base | 32'(a[12:0])) & span_mask(prg_lg);
  endfunction

  function automatic cbsm_pkg::out_item_t map_access(input cbsm_pkg::in_item_t acc);
    cbsm_pkg::out_item_t res;
    logic                odd;
    logic                in_ram;
    logic [2:0]          r;
    logic [7:0]          d;
    res = '0;
    d = acc.write_data;
    odd = acc.address[0];
    in_ram = (acc.address[15:13] == 3'b011);
    if (acc.mode == AccWrite) begin
      last_wr = d;
      if (in_ram) begin
        res.target = cbsm_pkg::TgtPrgRam;
        res.mem_index = IndexWidth'(32'(acc.address[12:0]) & span_mask({1'b0, ram_lg}));
      end else if (acc.address[15]) begin
        case (acc.address[14:13])
          cbsm_pkg::GrpBank: begin
            if (!odd) begin
              bank_sel = d;
            end else begin
              r = bank_sel[2:0];
              if (int'(r) < PrgBankBase) begin
                chr_bank[r] = (int'(r) < WideChrBanks) ? (d & 8'hFE) : d;
              end else begin
                prg_bank[int'(r) - PrgBankBase] = d[5:0];
              end
            end
          end
          cbsm_pkg::GrpMirror: begin
            if (!odd) mirror = d[0];
            else protect = d;
          end
          cbsm_pkg::GrpIrqCfg: begin
            if (!odd) latch = d;
            else reload = 1'b1;
          end
          default: begin
            irq_en = odd;
          end
        endcase
      end
    end else begin
      if (acc.address[15:13] == 3'b000) begin
        res.target = cbsm_pkg::TgtChrRom;
        res.mem_index = IndexWidth'(chr_lookup(acc.address));
      end else if (in_ram) begin
        res.target = cbsm_pkg::TgtPrgRam;
        res.mem_index = IndexWidth'(32'(acc.address[12:0]) & span_mask({1'b0, ram_lg}));
      end else if (acc.address[15]) begin
        res.target = cbsm_pkg::TgtPrgRom;
        res.mem_index = IndexWidth'(prg_lookup(acc.address));
      end
    end
    res.open_bus_value = last_wr;
    res.mirror_select = {1'b1, mirror};
    res.irq_enable_out = irq_en;
    res.irq_reload_out = reload;
    res.irq_latch_out = latch;
    res.ram_protect_out = protect;
    return res;
  endfunction

  function automatic cbsm_pkg::in_item_t random_access();
    cbsm_pkg::in_item_t acc;
    int unsigned        region;
    acc.mode = ($urandom_range(99) < 45) ? AccWrite : AccRead;
    acc.write_data = 8'($urandom_range(255));
    region = $urandom_range(9);
    if (region < 3) begin
      acc.address = {3'b000, 13'($urandom_range(8191))};
    end else if (region == 3) begin
      acc.address = 16'(16'h2000 + $urandom_range(16'h3FFF));
    end else if (region < 6) begin
      acc.address = {3'b011, 13'($urandom_range(8191))};
    end else begin
      acc.address = {1'b1, 15'($urandom_range(32767))};
    end
    return acc;
  endfunction

  task automatic send_access(input cbsm_pkg::in_item_t acc, input logic typed,
                             input logic [1:0] tgt, input logic [IndexWidth-1:0] idx);
    cbsm_pkg::out_item_t want;
    in_valid <= 1'b1;
    in_item <= acc;
    do @(posedge clk); while (!in_ready);
    want = map_access(acc);
    if (typed) begin
      want.target = tgt;
      want.mem_index = idx;
    end
    pending_results.push_back(want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_size(input logic [1:0] idx, input logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      cbsm_pkg::CfgChrRomSize: chr_lg = val;
      cbsm_pkg::CfgPrgRomSize: prg_lg = val;
      cbsm_pkg::CfgPrgRamSize: ram_lg = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cbsm_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("unexpected result transaction: %p", out_item);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("target", want.target, out_item.target);
        check_field("mem_index", want.mem_index, out_item.mem_index);
        check_field("open_bus_value", want.open_bus_value, out_item.open_bus_value);
        check_field("mirror_select", want.mirror_select, out_item.mirror_select);
        check_field("irq_enable_out", want.irq_enable_out, out_item.irq_enable_out);
        check_field("irq_reload_out", want.irq_reload_out, out_item.irq_reload_out);
        check_field("irq_latch_out", want.irq_latch_out, out_item.irq_latch_out);
        check_field("ram_protect_out", want.ram_protect_out, out_item.ram_protect_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cbsm_pkg::in_item_t sel;
    cbsm_pkg::in_item_t data;
    int                 n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_access(directed_rows[i].acc, directed_rows[i].typed,
                  directed_rows[i].tgt, directed_rows[i].idx);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_size(cbsm_pkg::CfgChrRomSize, size_plan[p].chr);
      write_size(cbsm_pkg::CfgPrgRomSize, size_plan[p].prg);
      write_size(cbsm_pkg::CfgPrgRamSize, size_plan[p].ram);
      if (p == 2) begin
        write_size(CfgUnused, 5'($urandom_range(31)));
      end
      // one phase runs with both sides always ready
      idle_pct = (p == 3) ? 0 : 18;
      stall_pct = (p == 3) ? 0 : 18;
      n = 0;
      while (n < PhaseItems) begin
        if ($urandom_range(99) < 25) begin
          // bank select followed by bank data, random content
          sel = '{AccWrite, {3'b100, 12'($urandom_range(4095)), 1'b0},
                  8'($urandom_range(255))};
          data = '{AccWrite, {3'b100, 12'($urandom_range(4095)), 1'b1},
                   8'($urandom_range(255))};
          send_access(sel, Predicted, cbsm_pkg::TgtNone, '0);
          send_access(data, Predicted, cbsm_pkg::TgtNone, '0);
          n += 2;
        end else begin
          send_access(random_access(), Predicted, cbsm_pkg::TgtNone, '0);
          n++;
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
